### hdl/bqtdf2_pkg.sv
// Package of shared types and constants for the transposed direct form II biquad filter.
package bqtdf2_pkg;

  // Configuration register index port width and register indexes.
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_B2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A1 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_A2 = 3'd4;

  // Sequencer states: idle, one per use of the shared multiplier, and the final step.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_MA1L,
    ST_MA1H,
    ST_MA2L,
    ST_MA2H,
    ST_FIN
  } bqtdf2_state_e;

  // Multiplier operand A: the sample, or the low or high half of y.
  typedef enum logic [1:0] {
    OPND_X,
    OPND_YLO,
    OPND_YHI
  } bqtdf2_opnd_e;

  // Multiplier operand B: one of the five coefficients.
  typedef enum logic [2:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A1,
    COEF_A2
  } bqtdf2_coef_e;

  // Datapath register update that goes with a step.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_Y,
    ACT_N1_INIT,
    ACT_N2_INIT,
    ACT_N1_SUB,
    ACT_FINISH
  } bqtdf2_act_e;

  typedef struct packed {
    logic en;   // load the product register
    logic acc;  // add to the product register instead of replacing it
    logic hi;   // shift the new product up by the low-half width of y
  } bqtdf2_mac_ctrl_t;

  typedef struct packed {
    logic             in_ready;
    bqtdf2_mac_ctrl_t mac;
    bqtdf2_opnd_e     opnd_sel;
    bqtdf2_coef_e     coef_sel;
    bqtdf2_act_e      act;
  } bqtdf2_ctrl_t;

endpackage

### hdl/biquad_tdf2_filter.sv
// Top level of the transposed direct form II biquad filter with a shared multiplier.
// A sample transferred in goes step by step through the one multiplier; the final step
// then loads its result, shown on m_axis_tvalid_o, and waits there while the slot is full.
// The sequencer takes the next sample in its final step while the output register drains.
// Async reset (rst_ni low) zeroes both delays, handshake state and b1 to a2; b0 = 1.0.
module biquad_tdf2_filter #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 18,
  parameter int unsigned COEF_FRAC    = 14,
  parameter int unsigned STATE_WIDTH  = 40,
  localparam int unsigned TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [bqtdf2_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [COEF_WIDTH-1:0]             cfg_wdata_i,
  // Input stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [TDATA_W-1:0]                s_axis_tdata_i,  // sample_in, zero padding
  input  logic                              s_axis_tlast_i,  // block_end
  // Output stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [TDATA_W-1:0]                m_axis_tdata_o,  // sample_out, zero padding
  output logic                              m_axis_tlast_o   // block_end_out
);

  // Width of a scaled sample-by-coefficient product.
  localparam int unsigned XB_W   = SAMPLE_WIDTH + COEF_WIDTH - COEF_FRAC;
  localparam int unsigned Y_BASE = (STATE_WIDTH > XB_W) ? STATE_WIDTH : XB_W;
  // The unsaturated output y carries one bit of headroom over its largest addend.
  localparam int unsigned Y_W    = ((Y_BASE > SAMPLE_WIDTH) ? Y_BASE : SAMPLE_WIDTH) + 1;
  // y is fed to the multiplier in two halves: an unsigned low half and a signed high half.
  localparam int unsigned LO_W   = Y_W / 2;
  localparam int unsigned HI_W   = Y_W - LO_W;
  localparam int unsigned A_MAX1 = (SAMPLE_WIDTH > LO_W + 1) ? SAMPLE_WIDTH : LO_W + 1;
  localparam int unsigned A_W    = (A_MAX1 > HI_W) ? A_MAX1 : HI_W;
  // The product register holds a full y-by-coefficient product.
  localparam int unsigned P_W    = Y_W + COEF_WIDTH;
  localparam int unsigned FS_W   = P_W - COEF_FRAC;
  localparam int unsigned ACC_B  = (FS_W > STATE_WIDTH) ? FS_W : STATE_WIDTH;
  // The next-state sums add up to three terms, so they get two bits of headroom.
  localparam int unsigned ACC_W  = ACC_B + 2;

  bqtdf2_pkg::bqtdf2_ctrl_t ctrl;

  logic signed [COEF_WIDTH-1:0]   coef_b0_q;
  logic signed [COEF_WIDTH-1:0]   coef_b1_q;
  logic signed [COEF_WIDTH-1:0]   coef_b2_q;
  logic signed [COEF_WIDTH-1:0]   coef_a1_q;
  logic signed [COEF_WIDTH-1:0]   coef_a2_q;

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic                           last_q;
  logic signed [Y_W-1:0]          y_q;
  logic signed [ACC_W-1:0]        n1_q;
  logic signed [ACC_W-1:0]        n2_q;
  logic signed [STATE_WIDTH-1:0]  delay_one_q;
  logic signed [STATE_WIDTH-1:0]  delay_two_q;

  logic                           out_valid_q;
  logic [SAMPLE_WIDTH-1:0]        out_data_q;
  logic                           out_last_q;

  logic                           out_free;
  logic                           in_xfer;
  logic signed [A_W-1:0]          mac_a;
  logic signed [COEF_WIDTH-1:0]   mac_b;
  logic signed [P_W-1:0]          mac_prod;
  logic signed [ACC_W-1:0]        prod_fs;
  logic signed [Y_W-1:0]          y_d;
  logic signed [ACC_W-1:0]        n2_fin;

  // Clamp a next-state sum to the signed state range.
  function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-STATE_WIDTH:0] upper;
    upper = v[ACC_W-1:STATE_WIDTH-1];
    if ((&upper) || (~|upper)) begin
      return v[STATE_WIDTH-1:0];
    end
    return {v[ACC_W-1], {(STATE_WIDTH-1){~v[ACC_W-1]}}};
  endfunction

  // Clamp the unsaturated output to the signed sample range.
  function automatic logic [SAMPLE_WIDTH-1:0] sat_sample(input logic signed [Y_W-1:0] v);
    logic [Y_W-SAMPLE_WIDTH:0] upper;
    upper = v[Y_W-1:SAMPLE_WIDTH-1];
    if ((&upper) || (~|upper)) begin
      return v[SAMPLE_WIDTH-1:0];
    end
    return {v[Y_W-1], {(SAMPLE_WIDTH-1){~v[Y_W-1]}}};
  endfunction

  // The output slot may take a new result when it is empty or being drained this cycle.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = ctrl.in_ready;
  assign in_xfer         = s_axis_tvalid_i && ctrl.in_ready;

  bqtdf2_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctrl.opnd_sel)
      bqtdf2_pkg::OPND_X:   mac_a = A_W'(x_q);
      bqtdf2_pkg::OPND_YLO: mac_a = A_W'($signed({1'b0, y_q[LO_W-1:0]}));
      bqtdf2_pkg::OPND_YHI: mac_a = A_W'($signed(y_q[Y_W-1:LO_W]));
      default:              mac_a = A_W'(x_q);
    endcase
    unique case (ctrl.coef_sel)
      bqtdf2_pkg::COEF_B0: mac_b = coef_b0_q;
      bqtdf2_pkg::COEF_B1: mac_b = coef_b1_q;
      bqtdf2_pkg::COEF_B2: mac_b = coef_b2_q;
      bqtdf2_pkg::COEF_A1: mac_b = coef_a1_q;
      bqtdf2_pkg::COEF_A2: mac_b = coef_a2_q;
      default:             mac_b = coef_b0_q;
    endcase
  end

  bqtdf2_mac #(
    .A_W   (A_W),
    .B_W   (COEF_WIDTH),
    .P_W   (P_W),
    .SHIFT (LO_W)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl.mac),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (mac_prod)
  );

  // The arithmetic shift of the finished product rounds toward minus infinity.
  assign prod_fs = ACC_W'(mac_prod >>> COEF_FRAC);
  assign y_d     = Y_W'(mac_prod >>> COEF_FRAC) + Y_W'(delay_one_q);
  assign n2_fin  = n2_q - prod_fs;

  // Coefficient registers. Writes to indexes past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= COEF_WIDTH'(1) << COEF_FRAC;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        bqtdf2_pkg::REG_COEF_B0: coef_b0_q <= $signed(cfg_wdata_i);
        bqtdf2_pkg::REG_COEF_B1: coef_b1_q <= $signed(cfg_wdata_i);
        bqtdf2_pkg::REG_COEF_B2: coef_b2_q <= $signed(cfg_wdata_i);
        bqtdf2_pkg::REG_COEF_A1: coef_a1_q <= $signed(cfg_wdata_i);
        bqtdf2_pkg::REG_COEF_A2: coef_a2_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Input capture. A new sample may land in the same cycle as the previous one finishes,
  // since the finishing step no longer reads the sample register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q    <= $signed(s_axis_tdata_i[SAMPLE_WIDTH-1:0]);
      last_q <= s_axis_tlast_i;
    end
  end

  // Working registers for y and the two next-state sums.
  always_ff @(posedge clk_i) begin
    case (ctrl.act)
      bqtdf2_pkg::ACT_Y:       y_q  <= y_d;
      bqtdf2_pkg::ACT_N1_INIT: n1_q <= prod_fs + ACC_W'(delay_two_q);
      bqtdf2_pkg::ACT_N2_INIT: n2_q <= prod_fs;
      bqtdf2_pkg::ACT_N1_SUB:  n1_q <= n1_q - prod_fs;
      default: ;
    endcase
  end

  // Filter state. Both delays saturate; the output path saturates separately so the
  // feedback always sees the full-precision y.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_one_q <= '0;
      delay_two_q <= '0;
    end else if (ctrl.act == bqtdf2_pkg::ACT_FINISH) begin
      delay_one_q <= sat_state(n1_q);
      delay_two_q <= sat_state(n2_fin);
    end
  end

  // Output register. It holds a result until the downstream transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.act == bqtdf2_pkg::ACT_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.act == bqtdf2_pkg::ACT_FINISH) begin
      out_data_q <= sat_sample(y_q);
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDATA_W'(out_data_q);
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after a sample transfer");

  a_finish_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.act == bqtdf2_pkg::ACT_FINISH) |-> (!out_valid_q || m_axis_tready_i))
    else $error("result written over one not yet transferred");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(ctrl.act == bqtdf2_pkg::ACT_FINISH))
    else $error("output valid raised without a finishing step");
`endif

endmodule

### hdl/bqtdf2_mac.sv
// Shared signed multiply-accumulate unit with a registered product.
module bqtdf2_mac #(
  parameter int unsigned A_W   = 21,
  parameter int unsigned B_W   = 18,
  parameter int unsigned P_W   = 59,
  parameter int unsigned SHIFT = 20
) (
  input  logic                        clk_i,
  input  bqtdf2_pkg::bqtdf2_mac_ctrl_t ctrl_i,
  input  logic signed [A_W-1:0]       a_i,
  input  logic signed [B_W-1:0]       b_i,
  output logic signed [P_W-1:0]       prod_o
);

  logic signed [A_W+B_W-1:0] mult;
  logic signed [P_W-1:0]     ext;
  logic signed [P_W-1:0]     term;
  logic signed [P_W-1:0]     prod_d;
  logic signed [P_W-1:0]     prod_q;

  always_comb begin
    mult   = a_i * b_i;
    ext    = P_W'(mult);
    term   = ctrl_i.hi ? (ext <<< SHIFT) : ext;
    prod_d = ctrl_i.acc ? (prod_q + term) : term;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### hdl/bqtdf2_ctrl.sv
// Sequencer that steps one sample through the shared multiplier.
module bqtdf2_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     out_free_i,
  output bqtdf2_pkg::bqtdf2_ctrl_t ctrl_o
);

  bqtdf2_pkg::bqtdf2_state_e state_q;
  bqtdf2_pkg::bqtdf2_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqtdf2_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ctrl_o.in_ready = 1'b0;
    ctrl_o.mac.en   = 1'b0;
    ctrl_o.mac.acc  = 1'b0;
    ctrl_o.mac.hi   = 1'b0;
    ctrl_o.opnd_sel = bqtdf2_pkg::OPND_X;
    ctrl_o.coef_sel = bqtdf2_pkg::COEF_B0;
    ctrl_o.act      = bqtdf2_pkg::ACT_NONE;
    unique case (state_q)
      bqtdf2_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = bqtdf2_pkg::ST_MB0;
        end
      end
      bqtdf2_pkg::ST_MB0: begin
        ctrl_o.mac.en = 1'b1;
        state_d       = bqtdf2_pkg::ST_MB1;
      end
      bqtdf2_pkg::ST_MB1: begin
        ctrl_o.mac.en   = 1'b1;
        ctrl_o.coef_sel = bqtdf2_pkg::COEF_B1;
        ctrl_o.act      = bqtdf2_pkg::ACT_Y;
        state_d         = bqtdf2_pkg::ST_MB2;
      end
      bqtdf2_pkg::ST_MB2: begin
        ctrl_o.mac.en   = 1'b1;
        ctrl_o.coef_sel = bqtdf2_pkg::COEF_B2;
        ctrl_o.act      = bqtdf2_pkg::ACT_N1_INIT;
        state_d         = bqtdf2_pkg::ST_MA1L;
      end
      bqtdf2_pkg::ST_MA1L: begin
        ctrl_o.mac.en   = 1'b1;
        ctrl_o.opnd_sel = bqtdf2_pkg::OPND_YLO;
        ctrl_o.coef_sel = bqtdf2_pkg::COEF_A1;
        ctrl_o.act      = bqtdf2_pkg::ACT_N2_INIT;
        state_d         = bqtdf2_pkg::ST_MA1H;
      end
      bqtdf2_pkg::ST_MA1H: begin
        ctrl_o.mac.en   = 1'b1;
        ctrl_o.mac.acc  = 1'b1;
        ctrl_o.mac.hi   = 1'b1;
        ctrl_o.opnd_sel = bqtdf2_pkg::OPND_YHI;
        ctrl_o.coef_sel = bqtdf2_pkg::COEF_A1;
        state_d         = bqtdf2_pkg::ST_MA2L;
      end
      bqtdf2_pkg::ST_MA2L: begin
        ctrl_o.mac.en   = 1'b1;
        ctrl_o.opnd_sel = bqtdf2_pkg::OPND_YLO;
        ctrl_o.coef_sel = bqtdf2_pkg::COEF_A2;
        ctrl_o.act      = bqtdf2_pkg::ACT_N1_SUB;
        state_d         = bqtdf2_pkg::ST_MA2H;
      end
      bqtdf2_pkg::ST_MA2H: begin
        ctrl_o.mac.en   = 1'b1;
        ctrl_o.mac.acc  = 1'b1;
        ctrl_o.mac.hi   = 1'b1;
        ctrl_o.opnd_sel = bqtdf2_pkg::OPND_YHI;
        ctrl_o.coef_sel = bqtdf2_pkg::COEF_A2;
        state_d         = bqtdf2_pkg::ST_FIN;
      end
      bqtdf2_pkg::ST_FIN: begin
        if (out_free_i) begin
          ctrl_o.act      = bqtdf2_pkg::ACT_FINISH;
          ctrl_o.in_ready = 1'b1;
          state_d         = in_valid_i ? bqtdf2_pkg::ST_MB0 : bqtdf2_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bqtdf2_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_reaches_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && ctrl_o.in_ready) |-> ##8 (state_q == bqtdf2_pkg::ST_FIN))
    else $error("accepted sample did not reach the final step in eight cycles");

  a_fin_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bqtdf2_pkg::ST_FIN && !out_free_i) |=> (state_q == bqtdf2_pkg::ST_FIN))
    else $error("final step left while the output slot was full");

  a_finish_keeps_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.act == bqtdf2_pkg::ACT_FINISH) |-> !ctrl_o.mac.en)
    else $error("product register loaded during the finishing step");
`endif

endmodule

### sim/bqtdf2_checker.sv
// Checker for the biquad filter: predicts every output transfer and compares it field by field.
module bqtdf2_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 18,
  parameter int unsigned COEF_FRAC    = 14,
  parameter int unsigned STATE_WIDTH  = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bqtdf2_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [COEF_WIDTH-1:0]             cfg_wdata_i,
  input  logic                              s_valid_i,
  input  logic                              s_ready_i,
  input  logic [SAMPLE_WIDTH-1:0]           s_sample_i,
  input  logic                              s_last_i,
  input  logic                              m_valid_i,
  input  logic                              m_ready_i,
  input  logic [SAMPLE_WIDTH-1:0]           m_sample_i,
  input  logic                              m_last_i,
  output int unsigned                       fail_cnt_o,
  output int unsigned                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    last;
  } filt_out_t;

  localparam logic signed [COEF_WIDTH-1:0] UNITY = COEF_WIDTH'(1) << COEF_FRAC;

  logic signed [COEF_WIDTH-1:0] b0 = UNITY;
  logic signed [COEF_WIDTH-1:0] b1 = '0;
  logic signed [COEF_WIDTH-1:0] b2 = '0;
  logic signed [COEF_WIDTH-1:0] a1 = '0;
  logic signed [COEF_WIDTH-1:0] a2 = '0;
  longint      delay_one = 0;
  longint      delay_two = 0;
  filt_out_t   filt_out_q [$];
  int unsigned fail_cnt = 0;
  int unsigned pending  = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending;

  // Product scaled back to sample units; >>> on a signed value rounds toward minus infinity.
  function automatic longint scale(input longint v, input logic signed [COEF_WIDTH-1:0] c);
    return (v * longint'(c)) >>> COEF_FRAC;
  endfunction

  function automatic longint clamp(input longint v, input int unsigned w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    longint    x, y, n1, n2;
    filt_out_t want;
    if (!rst_ni) begin
      b0 = UNITY;
      b1 = '0;
      b2 = '0;
      a1 = '0;
      a2 = '0;
      delay_one = 0;
      delay_two = 0;
      filt_out_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          bqtdf2_pkg::REG_COEF_B0: b0 = cfg_wdata_i;
          bqtdf2_pkg::REG_COEF_B1: b1 = cfg_wdata_i;
          bqtdf2_pkg::REG_COEF_B2: b2 = cfg_wdata_i;
          bqtdf2_pkg::REG_COEF_A1: a1 = cfg_wdata_i;
          bqtdf2_pkg::REG_COEF_A2: a2 = cfg_wdata_i;
          default: ;
        endcase
      end
      // The output side is checked first so that a stray result is never matched
      // against a sample accepted on the same edge.
      if (m_valid_i && m_ready_i) begin
        if (filt_out_q.size() == 0) begin
          $display("%0t: unexpected output, sample_out %0d block_end_out %0b", $time,
                   $signed(m_sample_i), m_last_i);
          fail_cnt++;
        end else begin
          want = filt_out_q.pop_front();
          if (m_sample_i !== want.sample) begin
            $display("%0t: sample_out expected %0d actual %0d", $time,
                     $signed(want.sample), $signed(m_sample_i));
            fail_cnt++;
          end
          if (m_last_i !== want.last) begin
            $display("%0t: block_end_out expected %0b actual %0b", $time, want.last, m_last_i);
            fail_cnt++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        x  = longint'($signed(s_sample_i));
        y  = scale(x, b0) + delay_one;
        n1 = scale(x, b1) - scale(y, a1) + delay_two;
        n2 = scale(x, b2) - scale(y, a2);
        delay_one   = clamp(n1, STATE_WIDTH);
        delay_two   = clamp(n2, STATE_WIDTH);
        want.sample = SAMPLE_WIDTH'(clamp(y, SAMPLE_WIDTH));
        want.last   = s_last_i;
        filt_out_q.push_back(want);
      end
    end
    pending = filt_out_q.size();
  end

endmodule

### sim/tb_biquad_tdf2_filter.sv
// Testbench top for the biquad filter: reset, coefficient phases, sample stimulus and verdict.
module tb_biquad_tdf2_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COEF_W      = 18;
  localparam int unsigned CFG_AW      = bqtdf2_pkg::CFG_ADDR_W;
  // Settling time, in cycles, given once the last result is out, before coefficient writes.
  localparam int unsigned PIPE_CYCLES = 12;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam int unsigned HOLD_CYCLES = 200;

  localparam logic [SAMPLE_W-1:0] SMP_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SMP_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SMP_ZERO = '0;
  localparam logic [SAMPLE_W-1:0] SMP_ONE  = 1;
  localparam logic [SAMPLE_W-1:0] SMP_NEG1 = '1;
  localparam logic [COEF_W-1:0]   COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0]   COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0]   COEF_ZERO = '0;

  // A gentle low-pass section in Q3.14, stable and well inside the state range.
  localparam logic signed [COEF_W-1:0] LP_B0 = 18'sd1106;
  localparam logic signed [COEF_W-1:0] LP_B1 = 18'sd2212;
  localparam logic signed [COEF_W-1:0] LP_A1 = -18'sd18727;
  localparam logic signed [COEF_W-1:0] LP_A2 = 18'sd6764;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_AW-1:0]     cfg_addr  = '0;
  logic [COEF_W-1:0]     cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata   = '0;
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;
  logic                  m_tlast;

  // Idle odds, in percent per cycle, for the sample source and the result sink.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  // Each increment asks the sink for one long hold-off.
  int unsigned hold_req = 0;
  int unsigned fail_cnt;
  int unsigned pending;

  biquad_tdf2_filter dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  bqtdf2_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .s_valid_i  (s_tvalid),
    .s_ready_i  (s_tready),
    .s_sample_i (s_tdata),
    .s_last_i   (s_tlast),
    .m_valid_i  (m_tvalid),
    .m_ready_i  (m_tready),
    .m_sample_i (m_tdata),
    .m_last_i   (m_tlast),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs; a correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("FAIL biquad_tdf2_filter");
    $finish;
  end

  // Result sink. It stalls at random according to recv_idle_pct, and when the stimulus
  // asks for it, it refuses results without a break, so that the block
  // backs up and has to drop s_axis_tready_o while samples are still being offered.
  initial begin : sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one sample and returns at the edge where the transfer happened. tvalid is
  // left high so that back-to-back samples need no extra assignment; a gap, if any,
  // is taken here afterwards, with tvalid low and junk on tdata meanwhile.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= SAMPLE_W'($urandom);
      s_tlast  <= 1'($urandom);
      @(posedge clk);
    end
  endtask

  // Stops offering samples and waits until every predicted result has been transferred
  // out, then lets the pipeline settle so that coefficient writes hit an idle block.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // One register write per cycle; the write enable stays high across the burst and
  // drops once at the end. The unused indexes above coef_a2 get random data first,
  // which the block must ignore.
  task automatic put_reg(input logic [CFG_AW-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, b1, b2, a1, a2);
    for (int i = bqtdf2_pkg::REG_COEF_A2 + 1; i < (1 << CFG_AW); i++) begin
      put_reg(CFG_AW'(i), COEF_W'($urandom));
    end
    put_reg(bqtdf2_pkg::REG_COEF_B0, b0);
    put_reg(bqtdf2_pkg::REG_COEF_B1, b1);
    put_reg(bqtdf2_pkg::REG_COEF_B2, b2);
    put_reg(bqtdf2_pkg::REG_COEF_A1, a1);
    put_reg(bqtdf2_pkg::REG_COEF_A2, a2);
    cfg_we <= 1'b0;
  endtask

  // Samples lean toward the full-scale values and tiny values of either sign.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SAMPLE_W'($urandom_range(31)) - SAMPLE_W'(16);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // A tame coefficient lies within +/-1.0; otherwise any 18-bit pattern goes.
  function automatic logic [COEF_W-1:0] pick_coef(input bit tame);
    if (tame) return COEF_W'($urandom_range(32768)) - COEF_W'(16384);
    return COEF_W'($urandom);
  endfunction

  initial begin : stimulus
    logic [COEF_W-1:0] cb0, cb1, cb2, ca1, ca2;
    bit                tame;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 80;

    // Reset coefficients make the filter a straight pass-through: check the sample
    // extremes and both values of the block-end flag against it.
    send_sample(SMP_ZERO, 1'b0);
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_NEG1, 1'b1);
    send_sample(SMP_ONE, 1'b0);
    wait_drained();

    // A gain of almost eight drives the output into saturation at both ends.
    load_coefs(COEF_MAX, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    send_sample(SMP_MAX, 1'b0);
    wait_drained();

    // Strong positive feedback through a1 blows up the state until both delays
    // saturate; the feedback keeps running on the unsaturated output value.
    load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    repeat (10) send_sample(SMP_MAX, 1'b0);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      // First the source idles little and the sink a lot, then the reverse, then
      // neither of them idles.
      if (p == 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 9;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // With no feedback, two zero samples clear both delays, so each phase starts
      // from a clean state even after a saturating one.
      load_coefs(pick_coef(1'b0), pick_coef(1'b0), pick_coef(1'b0), COEF_ZERO, COEF_ZERO);
      send_sample(SMP_ZERO, 1'b0);
      send_sample(SMP_ZERO, 1'b1);
      wait_drained();

      tame = (p % 2 == 0);
      case (p)
        0: begin
          cb0 = LP_B0;
          cb1 = LP_B1;
          cb2 = LP_B0;
          ca1 = LP_A1;
          ca2 = LP_A2;
        end
        1: begin
          cb0 = COEF_MAX;
          cb1 = COEF_MAX;
          cb2 = COEF_MAX;
          ca1 = COEF_MAX;
          ca2 = COEF_MAX;
        end
        2: begin
          cb0 = COEF_MIN;
          cb1 = COEF_MIN;
          cb2 = COEF_MIN;
          ca1 = COEF_MIN;
          ca2 = COEF_MIN;
        end
        default: begin
          cb0 = pick_coef(tame);
          cb1 = pick_coef(tame);
          cb2 = pick_coef(tame);
          ca1 = pick_coef(tame);
          // A non-negative a2 up to 0.5 with |a1| within 1.0 keeps the poles inside.
          ca2 = tame ? COEF_W'($urandom_range(8192)) : pick_coef(1'b0);
        end
      endcase
      load_coefs(cb0, cb1, cb2, ca1, ca2);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // In a phase where the source never idles, the sink goes quiet for a long
        // stretch so that the block fills up and stalls its input.
        if (p == 8 && k == 20) hold_req++;
        send_sample(pick_sample(), $urandom_range(7) == 0);
      end
      wait_drained();
    end

    if (fail_cnt == 0) begin
      $display("PASS biquad_tdf2_filter");
    end else begin
      $display("FAIL biquad_tdf2_filter");
    end
    $finish;
  end

endmodule
